[rtl/iee_pkg.sv]
// Shared types, codes and helpers for the infix expression evaluator.
// No dependencies.
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int PRIO_ADDSUB     = 10;
    localparam int PRIO_MUL        = 20;

    // token kinds
    localparam logic [2:0] TK_OPERAND = 3'd0;
    localparam logic [2:0] TK_OPEN    = 3'd1;
    localparam logic [2:0] TK_CLOSE   = 3'd2;
    localparam logic [2:0] TK_PLUS    = 3'd3;
    localparam logic [2:0] TK_MINUS   = 3'd4;
    localparam logic [2:0] TK_TIMES   = 3'd5;
    localparam logic [2:0] TK_END     = 3'd6;
    localparam logic [2:0] TK_UNUSED  = 3'd7;

    // operator stack codes
    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;
    localparam logic [1:0] OP_MUL  = 2'd3;

    // status codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MISSING  = 2'd1;
    localparam logic [1:0] ERR_BRACKET  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [63:0] operand_value;
    } t_in_req;

    typedef struct packed {
        logic signed [63:0] expr_value;
        logic [1:0]         status;
    } t_out_req;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH_VAL,
        DP_PUSH_OP,
        DP_POP,
        DP_FETCH,
        DP_ADDSUB,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_SET_ERR,
        DP_FINISH
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd    cmd;
        logic [1:0] err;
    } t_dp_ctl;

    typedef struct packed {
        logic [2:0] kind;
        logic       err_set;
        logic       op_empty;
        logic       op_break;
        logic       val_lt2;
        logic [1:0] curop;
    } t_dp_sts;

    function automatic int prio_of(input logic [1:0] op);
        return (op == OP_MUL) ? PRIO_MUL : PRIO_ADDSUB;
    endfunction

endpackage

[rtl/infix_expression_evaluator_unit.sv]
// Top level of the infix expression evaluator: controller plus datapath.
// Uses iee_pkg, iee_ctrl, iee_dpath.
//
//  channel  direction  handshake               payload
//  input    in         i_in_valid/o_in_ready   i_in_req  (token_kind, operand_value)
//  result   out        o_out_valid/i_out_ready o_out_req (expr_value, status)
//
// Operand and open bracket requests are loaded and then pushed; an operator or
// close bracket adds a stack check per step plus a pop, fetch and apply for each
// applied add/subtract (or popped open bracket), and a pop, fetch and three passes
// through the shared half-width multiplier for each applied times. The end request
// adds a finish step, held off while the previous result still waits; then the result
// sits in a register while the next request is accepted. Synchronous active-low reset
// empties both stacks; no clearing pass is needed.
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iee_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output iee_pkg::t_out_req o_out_req
);
    import iee_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    iee_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_ctl(ctl)
    );

    iee_dpath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_req(i_in_req),
        .i_ctl(ctl), .o_sts(sts), .o_out_req(o_out_req)
    );
endmodule

[rtl/iee_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/iee_dpath.sv]
// Datapath: operator and value stacks (top entry in a register, rest in RAM),
// shared half-width multiplier, error and result registers. Uses iee_pkg, iee_ram.
module iee_dpath #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iee_pkg::t_in_req  i_in_req,
    input  iee_pkg::t_dp_ctl  i_ctl,
    output iee_pkg::t_dp_sts  o_sts,
    output iee_pkg::t_out_req o_out_req
);
    import iee_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int W  = VALUE_WIDTH;
    localparam int H  = (VALUE_WIDTH + 1) / 2;

    logic [2:0]    r_kind;
    logic [W-1:0]  r_opnd;
    logic [DW-1:0] r_vdepth, n_vdepth;
    logic [DW-1:0] r_odepth, n_odepth;
    logic [W-1:0]  r_vtos, n_vtos;
    logic [1:0]    r_otos, n_otos;
    logic [1:0]    r_curop, n_curop;
    logic [1:0]    r_err, n_err;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_prod, n_prod;
    t_out_req      r_res, n_res;

    logic          v_we, o_we;
    logic [AW-1:0] v_waddr, o_waddr, v_raddr, o_raddr;
    logic [W-1:0]  v_rdata;
    logic [1:0]    o_rdata;
    logic [1:0]    new_op;
    logic [H-1:0]  m_x, m_y;
    logic [2*H-1:0] m_p;
    logic [1:0]    fin_code;

    // stack RAMs hold everything below the top entry
    iee_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(r_vtos),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    iee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_oram (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(r_otos),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    assign v_waddr = AW'(r_vdepth - DW'(1));
    assign o_waddr = AW'(r_odepth - DW'(1));
    assign v_raddr = AW'(r_vdepth - DW'(2));
    assign o_raddr = AW'(r_odepth - DW'(2));
    assign new_op  = 2'(r_kind - TK_CLOSE);

    // shared multiplier: low*low, then low*high, then high*low
    always_comb begin
        m_x = r_a[H-1:0];
        m_y = r_vtos[H-1:0];
        case (i_ctl.cmd)
            DP_MUL1: m_y = H'(r_vtos[W-1:H]);
            DP_MUL2: m_x = H'(r_a[W-1:H]);
            default: ;
        endcase
    end
    assign m_p = m_x * m_y;

    assign fin_code = (r_err == ERR_NONE && r_vdepth != DW'(1)) ? ERR_MISSING : r_err;

    // next-state logic per command
    always_comb begin
        n_vdepth = r_vdepth;
        n_odepth = r_odepth;
        n_vtos   = r_vtos;
        n_otos   = r_otos;
        n_curop  = r_curop;
        n_err    = r_err;
        n_a      = r_a;
        n_prod   = r_prod;
        n_res    = r_res;
        v_we     = 1'b0;
        o_we     = 1'b0;
        case (i_ctl.cmd)
            DP_PUSH_VAL: begin
                if (r_vdepth == DW'(STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    v_we     = (r_vdepth != '0);
                    n_vtos   = r_opnd;
                    n_vdepth = r_vdepth + DW'(1);
                end
            end
            DP_PUSH_OP: begin
                if (r_odepth == DW'(STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    o_we     = (r_odepth != '0);
                    n_otos   = (r_kind == TK_OPEN) ? OP_OPEN : new_op;
                    n_odepth = r_odepth + DW'(1);
                end
            end
            DP_POP: begin
                n_curop  = r_otos;
                n_odepth = r_odepth - DW'(1);
            end
            DP_FETCH: begin
                n_otos = o_rdata;
                n_a    = v_rdata;
            end
            DP_ADDSUB: begin
                n_vtos   = (r_curop == OP_SUB) ? r_a - r_vtos : r_a + r_vtos;
                n_vdepth = r_vdepth - DW'(1);
            end
            DP_MUL0: n_prod = W'(m_p);
            DP_MUL1: n_prod = r_prod + (W'(m_p) << H);
            DP_MUL2: begin
                n_vtos   = r_prod + (W'(m_p) << H);
                n_vdepth = r_vdepth - DW'(1);
            end
            DP_SET_ERR: begin
                if (r_err == ERR_NONE) begin
                    n_err = i_ctl.err;
                end
            end
            DP_FINISH: begin
                n_res.status     = fin_code;
                n_res.expr_value = (fin_code == ERR_NONE) ? 64'(signed'(r_vtos)) : '0;
                n_vdepth         = '0;
                n_odepth         = '0;
                n_err            = ERR_NONE;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdepth <= '0;
            r_odepth <= '0;
            r_err    <= ERR_NONE;
        end else begin
            r_vdepth <= n_vdepth;
            r_odepth <= n_odepth;
            r_err    <= n_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == DP_LOAD) begin
            r_kind <= i_in_req.token_kind;
            r_opnd <= i_in_req.operand_value[W-1:0];
        end
        r_vtos  <= n_vtos;
        r_otos  <= n_otos;
        r_curop <= n_curop;
        r_a     <= n_a;
        r_prod  <= n_prod;
        r_res   <= n_res;
    end

    // status to controller
    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.err_set  = (r_err != ERR_NONE);
        o_sts.op_empty = (r_odepth == '0);
        o_sts.op_break = (r_otos == OP_OPEN) || (prio_of(r_otos) < prio_of(new_op));
        o_sts.val_lt2  = (r_vdepth < DW'(2));
        o_sts.curop    = r_curop;
    end

    assign o_out_req = r_res;
endmodule

[rtl/iee_ctrl.sv]
// Controller FSM: sequences pushes, pops and operator application per token.
// Uses iee_pkg.
module iee_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  iee_pkg::t_dp_sts i_sts,
    output iee_pkg::t_dp_ctl o_ctl
);
    import iee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CLOSE_CHK, S_BIN_CHK, S_END_CHK,
        S_POP, S_FETCH, S_APPLY, S_MUL1, S_MUL2, S_END_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    t_state loop_st;

    // loop state to go back to after one operator is applied
    always_comb begin
        case (i_sts.kind)
            TK_CLOSE: loop_st = S_CLOSE_CHK;
            TK_END:   loop_st = S_END_CHK;
            default:  loop_st = S_BIN_CHK;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid && !i_out_ready;
        o_ctl.cmd = DP_NOP;
        o_ctl.err = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = DP_LOAD;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if (i_sts.kind == TK_END) begin
                    n_state = S_END_CHK;
                end else if (i_sts.kind == TK_UNUSED || i_sts.err_set) begin
                    n_state = S_IDLE;
                end else begin
                    case (i_sts.kind)
                        TK_OPERAND: o_ctl.cmd = DP_PUSH_VAL;
                        TK_OPEN:    o_ctl.cmd = DP_PUSH_OP;
                        TK_CLOSE:   n_state   = S_CLOSE_CHK;
                        default:    n_state   = S_BIN_CHK;
                    endcase
                end
            end
            S_CLOSE_CHK: begin
                if (i_sts.err_set) begin
                    n_state = S_IDLE;
                end else if (i_sts.op_empty) begin
                    o_ctl.cmd = DP_SET_ERR;
                    o_ctl.err = ERR_BRACKET;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_BIN_CHK: begin
                if (i_sts.err_set) begin
                    n_state = S_IDLE;
                end else if (i_sts.op_empty || i_sts.op_break) begin
                    o_ctl.cmd = DP_PUSH_OP;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_END_CHK: begin
                n_state = (i_sts.err_set || i_sts.op_empty) ? S_END_FIN : S_POP;
            end
            S_POP: begin
                o_ctl.cmd = DP_POP;
                n_state   = S_FETCH;
            end
            S_FETCH: begin
                o_ctl.cmd = DP_FETCH;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                n_state = loop_st;
                if (i_sts.curop == OP_OPEN) begin
                    // open bracket popped: closes a group, or is left over at end
                    if (i_sts.kind == TK_CLOSE) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.cmd = DP_SET_ERR;
                        o_ctl.err = ERR_BRACKET;
                    end
                end else if (i_sts.val_lt2) begin
                    o_ctl.cmd = DP_SET_ERR;
                    o_ctl.err = ERR_MISSING;
                end else if (i_sts.curop == OP_MUL) begin
                    o_ctl.cmd = DP_MUL0;
                    n_state   = S_MUL1;
                end else begin
                    o_ctl.cmd = DP_ADDSUB;
                end
            end
            S_MUL1: begin
                o_ctl.cmd = DP_MUL1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.cmd = DP_MUL2;
                n_state   = loop_st;
            end
            S_END_FIN: begin
                // wait until the result register is free
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.cmd = DP_FINISH;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
endmodule
